// ===== rtl/tmu_pkg.sv =====
// ============================================================================
// tmu_pkg: shared types and constants for the ticket mutex unit
// Ticket arithmetic, request and result codes, and the structs that pass
// between the decision engine and the waiter file.
// ============================================================================
`default_nettype none

package tmu_pkg;

    // Sizing of the waiter queue and of thread identifiers
    localparam int QUEUE_DEPTH    = 16;
    localparam int THREAD_ID_BITS = 16;

    // Tickets count modulo twice the queue depth
    localparam int TICKET_MOD  = 2 * QUEUE_DEPTH;
    localparam int TICKET_BITS = $clog2(TICKET_MOD);
    localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = TICKET_BITS + 1;

    // Recursion depth counter
    localparam int HOLD_BITS = 16;

    // Field widths of the stream ports
    localparam int ACTION_BITS  = 2;
    localparam int STATUS_BITS  = 3;
    localparam int MODE_BITS    = 2;
    localparam int IN_DATA_W    = ((THREAD_ID_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_BITS + TICKET_BITS + THREAD_ID_BITS + HOLD_BITS;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    typedef logic [TICKET_BITS-1:0]    ticket_t;
    typedef logic [QIDX_BITS-1:0]      qidx_t;
    typedef logic [THREAD_ID_BITS-1:0] tid_t;
    typedef logic [HOLD_BITS-1:0]      hold_t;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_LOCK    = 2'd0,
        ACT_TRYLOCK = 2'd1,
        ACT_UNLOCK  = 2'd2
    } action_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_ACQUIRED   = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_DEADLOCK   = 3'd2,
        ST_BUSY       = 3'd3,
        ST_NOT_OWNER  = 3'd4,
        ST_UNLOCKED   = 3'd5,
        ST_QUEUE_FULL = 3'd6,
        ST_NEST_LIMIT = 3'd7
    } status_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_ERRCHECK  = 2'd1,
        MODE_RECURSIVE = 2'd2
    } mode_t;

    // Register word indexes on the configuration port
    localparam logic REG_MODE_IDX = 1'b0;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        tid_t                   thread_id;
    } req_t;

    typedef struct packed {
        status_t status;
        ticket_t ticket;
        tid_t    woken_thread;
        hold_t   nest_count;
    } res_t;

    typedef struct packed {
        logic  en;
        qidx_t addr;
        tid_t  data;
    } ring_wr_t;

    // Advance a ticket, wrapping at twice the queue depth
    function automatic ticket_t tick_inc(input ticket_t t);
        ticket_t r;
        if (t == TICKET_BITS'(TICKET_MOD - 1))
            r = '0;
        else
            r = t + 1'b1;
        return r;
    endfunction

    // Ring slot of a ticket: ticket modulo the queue depth
    function automatic qidx_t ring_index(input ticket_t t);
        ticket_t r;
        if (t >= TICKET_BITS'(QUEUE_DEPTH))
            r = t - TICKET_BITS'(QUEUE_DEPTH);
        else
            r = t;
        return r[QIDX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tmu_waiter_file.sv =====
// ============================================================================
// tmu_waiter_file: ring of waiting thread identifiers
// One slot per queued ticket; written at enqueue, read when ownership is
// handed on. Contents are undefined until written.
// ============================================================================
`default_nettype none

module tmu_waiter_file
    import tmu_pkg::*;
(
    input  wire logic     clk,
    input  wire ring_wr_t wr,
    input  wire qidx_t    rd_addr,
    output tid_t          rd_data
);

    tid_t slot_reg [QUEUE_DEPTH];

    // Store a waiter at its ticket slot
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            slot_reg[wr.addr] <= wr.data;
        end
    end

    // Look up the next ticket holder
    assign rd_data = slot_reg[rd_addr];

endmodule

`default_nettype wire

// ===== rtl/tmu_engine.sv =====
// ============================================================================
// tmu_engine: mutex state and combinational request decision
// Holds the ticket counters, owner and nesting depth, decides each request
// in one pass and drives the waiter file.
// ============================================================================
`default_nettype none

module tmu_engine
    import tmu_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire req_t                 req,
    input  wire logic [MODE_BITS-1:0] mutex_mode,
    output res_t                      res,
    output ring_wr_t                  ring_wr,
    output qidx_t                     ring_rd_addr,
    input  wire tid_t                 ring_rd_data
);

    ticket_t next_ticket_reg, next_ticket_next;
    ticket_t now_serving_reg, now_serving_next;
    tid_t    owner_reg, owner_next;
    hold_t   hold_reg, hold_next;

    logic                held;
    logic                is_owner;
    logic                recursive;
    logic [CNT_BITS-1:0] outstanding;
    ticket_t             serve_inc;
    logic                enqueue;

    assign held      = (next_ticket_reg != now_serving_reg);
    assign is_owner  = held && (owner_reg == req.thread_id);
    assign recursive = (mutex_mode == MODE_RECURSIVE);
    assign serve_inc = tick_inc(now_serving_reg);

    // Count tickets drawn but not yet released
    always_comb
    begin
        if (next_ticket_reg >= now_serving_reg)
            outstanding = {1'b0, next_ticket_reg} - {1'b0, now_serving_reg};
        else
            outstanding = {1'b0, next_ticket_reg} + CNT_BITS'(TICKET_MOD)
                        - {1'b0, now_serving_reg};
    end

    assign ring_rd_addr = ring_index(serve_inc);

    // Decide the request
    always_comb
    begin
        next_ticket_next = next_ticket_reg;
        now_serving_next = now_serving_reg;
        owner_next       = owner_reg;
        hold_next        = hold_reg;
        enqueue          = 1'b0;
        res.status       = ST_BUSY;
        res.ticket       = '0;
        res.woken_thread = '0;

        case (req.action) inside
            ACT_LOCK, ACT_TRYLOCK:
            begin
                if (is_owner)
                begin
                    if (recursive)
                    begin
                        if (hold_reg == '1)
                            res.status = ST_NEST_LIMIT;
                        else
                        begin
                            hold_next  = hold_reg + 1'b1;
                            res.status = ST_ACQUIRED;
                        end
                    end
                    else if (req.action == ACT_LOCK)
                        res.status = ST_DEADLOCK;
                    else
                        res.status = ST_BUSY;
                end
                else if (!held)
                begin
                    res.ticket       = next_ticket_reg;
                    next_ticket_next = tick_inc(next_ticket_reg);
                    owner_next       = req.thread_id;
                    hold_next        = HOLD_BITS'(1);
                    res.status       = ST_ACQUIRED;
                end
                else if (req.action == ACT_TRYLOCK)
                    res.status = ST_BUSY;
                else if (outstanding >= CNT_BITS'(QUEUE_DEPTH))
                    res.status = ST_QUEUE_FULL;
                else
                begin
                    res.ticket       = next_ticket_reg;
                    enqueue          = 1'b1;
                    next_ticket_next = tick_inc(next_ticket_reg);
                    res.status       = ST_QUEUED;
                end
            end
            ACT_UNLOCK:
            begin
                if (!is_owner)
                    res.status = ST_NOT_OWNER;
                else if (hold_reg > HOLD_BITS'(1))
                begin
                    hold_next  = hold_reg - 1'b1;
                    res.status = ST_UNLOCKED;
                end
                else
                begin
                    now_serving_next = serve_inc;
                    if (serve_inc != next_ticket_reg)
                    begin
                        // Hand ownership straight to the next ticket holder
                        owner_next       = ring_rd_data;
                        hold_next        = HOLD_BITS'(1);
                        res.woken_thread = ring_rd_data;
                    end
                    else
                    begin
                        owner_next = '0;
                        hold_next  = '0;
                    end
                    res.status = ST_UNLOCKED;
                end
            end
            default:
            begin
                res.status = ST_BUSY;
            end
        endcase

        res.nest_count = hold_next;
    end

    // Queue the waiter at its ticket slot
    assign ring_wr.en   = fire && enqueue;
    assign ring_wr.addr = ring_index(next_ticket_reg);
    assign ring_wr.data = req.thread_id;

    // Commit the new state when a request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ticket_reg <= '0;
            now_serving_reg <= '0;
            owner_reg       <= '0;
            hold_reg        <= '0;
        end
        else if (fire)
        begin
            next_ticket_reg <= next_ticket_next;
            now_serving_reg <= now_serving_next;
            owner_reg       <= owner_next;
            hold_reg        <= hold_next;
        end
    end

`ifndef SYNTHESIS
    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding <= CNT_BITS'(QUEUE_DEPTH))
        else $error("more tickets outstanding than queue slots");

    a_free_no_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !held |-> (hold_reg == '0))
        else $error("free mutex carries a nesting depth");

    a_held_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
        held |-> (hold_reg != '0))
        else $error("held mutex has zero nesting depth");

    a_ticket_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_ticket_reg < TICKET_BITS'(TICKET_MOD - 1)
         || next_ticket_reg == TICKET_BITS'(TICKET_MOD - 1))
        && (now_serving_reg < TICKET_BITS'(TICKET_MOD - 1)
         || now_serving_reg == TICKET_BITS'(TICKET_MOD - 1)))
        else $error("ticket counter out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/ticket_mutex_unit.sv =====
// ============================================================================
// ticket_mutex_unit: FIFO-fair recursive mutex
// Stream front end with input and result registers, mode register on an
// APB-style port, decision engine and waiter ring.
// ============================================================================
// Each request (lock, try-lock or unlock for one thread) is taken into an
// input register and decided combinationally from the ticket counters,
// owner, nesting depth and one waiter-ring slot; the result passes through
// the result register to the master side. One request is taken every cycle
// while results are drained; the rate is set by the combinational decision
// path from the state registers through the ring read to the result
// register. A waiting result stalls the request side only once the input
// register also holds a request. The waiter ring needs no clearing after
// reset. Write mutex_mode only while no request is in flight.
`default_nettype none

module ticket_mutex_unit
    import tmu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // Request stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]     s_axis_tdata,   // [thread_id]
    input  wire logic [ACTION_BITS-1:0]   s_axis_tuser,   // [action]

    // Result stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_W-1:0]         m_axis_tdata,   // [status, ticket, woken_thread, nest_count]

    // Configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    logic                 in_valid_reg;
    req_t                 in_req_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic [MODE_BITS-1:0] mode_reg;

    logic     advance;
    logic     fire;
    res_t     res;
    ring_wr_t ring_wr;
    qidx_t    ring_rd_addr;
    tid_t     ring_rd_data;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE_IDX))
        begin
            mode_reg <= pwdata[MODE_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MODE_IDX) ? APB_DATA_BITS'(mode_reg) : '0;

    // Advance when the result slot is free or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the request in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg.action    <= s_axis_tuser;
            in_req_reg.thread_id <= s_axis_tdata[THREAD_ID_BITS-1:0];
        end
    end

    tmu_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .req          (in_req_reg),
        .mutex_mode   (mode_reg),
        .res          (res),
        .ring_wr      (ring_wr),
        .ring_rd_addr (ring_rd_addr),
        .ring_rd_data (ring_rd_data)
    );

    tmu_waiter_file u_waiters (
        .clk     (clk),
        .wr      (ring_wr),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // Register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.nest_count, out_res_reg.woken_thread,
                                        out_res_reg.ticket, out_res_reg.status});

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("request side stalled without a pending result");

    a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tvalid)
        else $error("decided request produced no result");
`endif

endmodule

`default_nettype wire

// ===== verif/tmu_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tmu_checker: result predictor and scoreboard for the ticket mutex unit
// Watches the request, result and configuration channels, predicts the
// outcome of every accepted request from its own copy of the mutex state and
// compares each accepted result, field by field, with the oldest prediction.
// ============================================================================

module tmu_checker
    import tmu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     s_axis_tvalid,
    input  wire logic                     s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]     s_axis_tdata,   // [thread_id]
    input  wire logic [ACTION_BITS-1:0]   s_axis_tuser,   // [action]

    input  wire logic                     m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0]    m_axis_tdata,   // [status, ticket, woken_thread, nest_count]

    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    input  wire logic                     pready,

    output int                            mismatches,
    output int                            pending_results,
    output tid_t                          holder_hint,
    output logic                          held_hint
);

    localparam int TICKET_LSB   = STATUS_BITS;
    localparam int WOKEN_LSB    = TICKET_LSB + TICKET_BITS;
    localparam int NEST_LSB     = WOKEN_LSB + THREAD_ID_BITS;
    localparam int REPORT_LIMIT = 10;

    localparam logic [APB_ADDR_BITS-1:0] MODE_ADDR = {REG_MODE_IDX, 2'b00};

    typedef struct packed {
        status_t status;
        ticket_t ticket;
        tid_t    woken;
        hold_t   depth;
    } lock_outcome_t;

    // Shadow of the mutex state
    logic [MODE_BITS-1:0] mode;
    ticket_t              next_ticket;
    ticket_t              now_serving;
    tid_t                 owner;
    hold_t                depth;
    tid_t                 waiters [QUEUE_DEPTH];

    lock_outcome_t        outcome_q [$];

    function automatic ticket_t next_in_turn(input ticket_t t);
        return (int'(t) == TICKET_MOD - 1) ? '0 : ticket_t'(t + 1'b1);
    endfunction

    function automatic int slot_of(input ticket_t t);
        return int'(t) % QUEUE_DEPTH;
    endfunction

    // Work out the outcome of one request and advance the shadow state
    function automatic lock_outcome_t decide(input logic [ACTION_BITS-1:0] act,
                                             input tid_t tid);
        lock_outcome_t r;
        logic          held;
        logic          owns;
        int            in_line;
        held    = (next_ticket != now_serving);
        owns    = held && (owner == tid);
        in_line = (int'(next_ticket) + TICKET_MOD - int'(now_serving)) % TICKET_MOD;
        r.status = ST_BUSY;
        r.ticket = '0;
        r.woken  = '0;
        if (act == ACT_LOCK || act == ACT_TRYLOCK)
        begin
            if (owns)
            begin
                if (mode == MODE_RECURSIVE)
                begin
                    if (depth == '1)
                    begin
                        r.status = ST_NEST_LIMIT;
                    end
                    else
                    begin
                        depth    = depth + 1'b1;
                        r.status = ST_ACQUIRED;
                    end
                end
                else
                begin
                    r.status = (act == ACT_LOCK) ? ST_DEADLOCK : ST_BUSY;
                end
            end
            else if (!held)
            begin
                r.ticket    = next_ticket;
                next_ticket = next_in_turn(next_ticket);
                owner       = tid;
                depth       = hold_t'(1);
                r.status    = ST_ACQUIRED;
            end
            else if (act == ACT_TRYLOCK)
            begin
                r.status = ST_BUSY;
            end
            else if (in_line >= QUEUE_DEPTH)
            begin
                r.status = ST_QUEUE_FULL;
            end
            else
            begin
                r.ticket                      = next_ticket;
                waiters[slot_of(next_ticket)] = tid;
                next_ticket                   = next_in_turn(next_ticket);
                r.status                      = ST_QUEUED;
            end
        end
        else if (act == ACT_UNLOCK)
        begin
            if (!owns)
            begin
                r.status = ST_NOT_OWNER;
            end
            else if (depth > hold_t'(1))
            begin
                depth    = depth - 1'b1;
                r.status = ST_UNLOCKED;
            end
            else
            begin
                // Final release: hand over to the next ticket holder, if any
                now_serving = next_in_turn(now_serving);
                if (now_serving != next_ticket)
                begin
                    owner   = waiters[slot_of(now_serving)];
                    depth   = hold_t'(1);
                    r.woken = owner;
                end
                else
                begin
                    owner = '0;
                    depth = '0;
                end
                r.status = ST_UNLOCKED;
            end
        end
        r.depth = depth;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input lock_outcome_t want,
                                 input lock_outcome_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected status %0d ticket %0d woken %h depth %0d",
                     $realtime, what, want.status, want.ticket, want.woken, want.depth);
            $display("%0t: %s: actual   status %0d ticket %0d woken %h depth %0d",
                     $realtime, what, got.status, got.ticket, got.woken, got.depth);
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result(input logic [OUT_DATA_W-1:0] data);
        lock_outcome_t got;
        lock_outcome_t want;
        got.status = status_t'(data[TICKET_LSB-1:0]);
        got.ticket = data[WOKEN_LSB-1:TICKET_LSB];
        got.woken  = data[NEST_LSB-1:WOKEN_LSB];
        got.depth  = data[NEST_LSB+HOLD_BITS-1:NEST_LSB];
        if (outcome_q.size() == 0)
        begin
            want = '0;
            note_mismatch("result with no request waiting", want, got);
        end
        else
        begin
            want = outcome_q.pop_front();
            if (got.status != want.status || got.ticket != want.ticket ||
                got.woken != want.woken || got.depth != want.depth)
                note_mismatch("result mismatch", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode        = MODE_NORMAL;
            next_ticket = '0;
            now_serving = '0;
            owner       = '0;
            depth       = '0;
            mismatches  = 0;
            outcome_q.delete();
            pending_results = 0;
            holder_hint <= '0;
            held_hint   <= 1'b0;
        end
        else
        begin
            // Mode register writes
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                mode = pwdata[MODE_BITS-1:0];

            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);

            if (s_axis_tvalid && s_axis_tready)
                outcome_q.push_back(decide(s_axis_tuser, s_axis_tdata[THREAD_ID_BITS-1:0]));

            pending_results = outcome_q.size();
            holder_hint <= owner;
            held_hint   <= (next_ticket != now_serving);
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stimulus and verdict for the ticket mutex unit
// Drives directed and random lock, try-lock and unlock requests under every
// mutex mode, including a full waiter ring and recursive nesting, with
// random stalls on both streams; the checker predicts and compares results.
// ============================================================================

module tb_top;
    import tmu_pkg::*;

    localparam int LONG_HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int SETTLE_CYCLES    = 4;

    localparam logic [ACTION_BITS-1:0]   ACT_UNUSED  = 2'd3;
    localparam logic [MODE_BITS-1:0]     MODE_UNUSED = 2'd3;
    localparam logic [APB_ADDR_BITS-1:0] MODE_ADDR   = {REG_MODE_IDX, 2'b00};
    localparam logic [APB_ADDR_BITS-1:0] SPARE_ADDR  = {~REG_MODE_IDX, 2'b00};

    logic                     clk = 1'b0;
    logic                     rst_n;

    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata;   // [thread_id]
    logic [ACTION_BITS-1:0]   s_axis_tuser;   // [action]

    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;   // [status, ticket, woken_thread, nest_count]

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int                       mismatches;
    int                       pending_results;
    tid_t                     holder_hint;
    logic                     held_hint;

    // Stall controls
    logic                     rx_bursty;
    logic                     hold_req;
    bit                       tx_bursty;

    always #10 clk = ~clk;

    ticket_mutex_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tmu_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .holder_hint     (holder_hint),
        .held_hint       (held_hint)
    );

    // Result sink: random back-pressure, plus one long hold on request
    initial
    begin : result_sink
        bit long_done;
        long_done = 1'b0;
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_req && !long_done)
            begin
                long_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (rx_bursty && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Abort when neither stream has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [ACTION_BITS-1:0] act, input tid_t tid);
        if (tx_bursty && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= IN_DATA_W'(tid);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Set the mode with junk in the unused upper bits
    task automatic write_mode(input logic [MODE_BITS-1:0] m);
        logic [APB_DATA_BITS-1:0] word;
        word                = $urandom();
        word[MODE_BITS-1:0] = m;
        write_reg(MODE_ADDR, word);
    endtask

    // Random traffic among a small crowd of threads, mostly well formed
    task automatic run_random_phase(input int count);
        tid_t crowd [6];
        int   roll;
        logic [ACTION_BITS-1:0] act;
        tid_t tid;
        foreach (crowd[i]) crowd[i] = tid_t'($urandom());
        crowd[5] = $urandom_range(0, 1) ? '1 : '0;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            tid  = crowd[$urandom_range(0, 5)];
            if (roll < 35)
            begin
                act = ACT_LOCK;
            end
            else if (roll < 50)
            begin
                act = ACT_TRYLOCK;
            end
            else if (roll < 94)
            begin
                act = ACT_UNLOCK;
                if (roll < 88 && held_hint)
                    tid = holder_hint;
            end
            else
            begin
                act = ACT_UNUSED;
                tid = tid_t'($urandom());
            end
            send_request(act, tid);
        end
    endtask

    initial
    begin : stimulus
        tid_t queue_ids [QUEUE_DEPTH];

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_bursty     <= 1'b1;
        hold_req      <= 1'b0;
        tx_bursty     = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(MODE_NORMAL);
        write_reg(SPARE_ADDR, $urandom());

        // Directed: free-mutex corners, deadlock, busy, queueing, hand-over
        send_request(ACT_UNLOCK,  16'h0005);
        send_request(ACT_UNUSED,  16'hFFFF);
        send_request(ACT_TRYLOCK, 16'h0F0F);
        send_request(ACT_UNLOCK,  16'h0F0F);
        send_request(ACT_LOCK,    16'h0001);
        send_request(ACT_LOCK,    16'h0001);
        send_request(ACT_TRYLOCK, 16'h0001);
        send_request(ACT_TRYLOCK, 16'hFFFF);
        send_request(ACT_LOCK,    16'h0000);
        send_request(ACT_LOCK,    16'hFFFF);
        send_request(ACT_LOCK,    16'hAAAA);
        send_request(ACT_LOCK,    16'h5555);
        send_request(ACT_UNLOCK,  16'h5555);
        send_request(ACT_UNUSED,  16'h0001);
        send_request(ACT_UNLOCK,  16'h0001);
        send_request(ACT_UNLOCK,  16'h0000);
        send_request(ACT_UNLOCK,  16'hFFFF);
        send_request(ACT_UNLOCK,  16'hAAAA);
        send_request(ACT_UNLOCK,  16'h5555);
        drain_results();

        // Fill the waiter ring, with one long hold on the result side
        tx_bursty = 1'b0;
        hold_req <= 1'b1;
        foreach (queue_ids[i]) queue_ids[i] = tid_t'((i << 12) | ($urandom() & 32'hFFF));
        foreach (queue_ids[i]) send_request(ACT_LOCK, queue_ids[i]);
        send_request(ACT_LOCK, queue_ids[7]);
        foreach (queue_ids[i]) send_request(ACT_UNLOCK, queue_ids[i]);
        tx_bursty = 1'b1;
        drain_results();
        hold_req <= 1'b0;

        // Recursive nesting
        write_mode(MODE_RECURSIVE);
        send_request(ACT_LOCK,    16'h00C3);
        send_request(ACT_LOCK,    16'h00C3);
        send_request(ACT_TRYLOCK, 16'h00C3);
        send_request(ACT_UNUSED,  16'h00C3);
        send_request(ACT_UNLOCK,  16'h00C3);
        send_request(ACT_UNLOCK,  16'h00C3);
        send_request(ACT_UNLOCK,  16'h00C3);
        drain_results();

        // Random phases across the modes
        tx_bursty = 1'b1;
        rx_bursty <= 1'b1;
        write_mode(MODE_RECURSIVE);
        run_random_phase(200);
        drain_results();
        write_mode(MODE_ERRCHECK);
        write_reg(SPARE_ADDR, 32'h0000_0002);
        run_random_phase(180);
        drain_results();
        write_mode(MODE_UNUSED);
        run_random_phase(150);
        drain_results();
        write_mode(MODE_NORMAL);
        run_random_phase(170);
        drain_results();

        // Closing stretch with no stalls
        tx_bursty = 1'b0;
        rx_bursty <= 1'b0;
        write_mode(MODE_RECURSIVE);
        run_random_phase(200);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
